// ----- hdl/utmdp_pkg.sv -----
// Shared types, constants and symbol mapping for the unary machine-description parser.
`default_nettype none

package utmdp_pkg;

    localparam int STATE_COUNT_DEF     = 16;
    localparam int SLOTS_PER_STATE_DEF = 8;
    localparam int TAPE_CELLS_DEF      = 256;

    localparam logic [7:0] SYM_OFFSET = 8'd94;
    localparam logic [7:0] SYM_LIMIT  = 8'd29;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CHAR_BLANK = 8'h5F;  // '_'

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    typedef enum logic [2:0] {
        KIND_TRANS      = 3'd0,
        KIND_TAPE       = 3'd1,
        KIND_SUMMARY    = 3'd2,
        KIND_BAD_STATE  = 3'd3,
        KIND_SLOTS_FULL = 3'd4,
        KIND_TAPE_FULL  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_TRANS = 3'b010,
        PH_TAPE  = 3'b100
    } phase_t;

    // Outcome of closing the direction field of one transition
    typedef struct packed {
        kind_t      kind;
        logic [3:0] from_state;
        logic [2:0] slot;
        logic [3:0] to_state;
        logic [7:0] read_symbol;
        logic [7:0] write_symbol;
        logic [1:0] direction;
    } commit_t;

    function automatic logic [7:0] sym_of(input logic [7:0] count);
        logic [7:0] v;
        logic [7:0] s;
        v = count - 8'd1;
        if (v == 8'd0)
            s = CHAR_ZERO;
        else if (v == 8'd1)
            s = CHAR_ONE;
        else if (v == 8'd2)
            s = CHAR_BLANK;
        else if (v < SYM_LIMIT)
            s = v + SYM_OFFSET;
        else
            s = CHAR_BLANK;
        return s;
    endfunction

    function automatic logic [1:0] dir_of(input logic [7:0] count);
        logic [1:0] d;
        if (count == 8'd1)
            d = DIR_LEFT;
        else if (count == 8'd2)
            d = DIR_RIGHT;
        else
            d = DIR_NONE;
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/utmdp_if.sv -----
// Valid/ready channel interfaces for description characters and parser results.
`default_nettype none

interface utmdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface utmdp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] from_state;
    logic [2:0] slot;
    logic [3:0] to_state;
    logic [7:0] read_symbol;
    logic [7:0] write_symbol;
    logic [1:0] direction;
    logic [7:0] tape_index;
    logic [7:0] tape_char;
    logic [4:0] state_count;
    logic [7:0] transition_count;
    logic       last;

    modport source (output valid, kind, from_state, slot, to_state, read_symbol,
                    write_symbol, direction, tape_index, tape_char, state_count,
                    transition_count, last, input ready);
    modport sink   (input valid, kind, from_state, slot, to_state, read_symbol,
                    write_symbol, direction, tape_index, tape_char, state_count,
                    transition_count, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/utmdp_commit.sv -----
// Transition commit check: state range, slot availability and field mapping.
`default_nettype none

module utmdp_commit import utmdp_pkg::*; #(
    parameter int STATE_COUNT     = STATE_COUNT_DEF,
    parameter int SLOTS_PER_STATE = SLOTS_PER_STATE_DEF,
    localparam int IDX_W = $clog2(STATE_COUNT),
    localparam int SF_W  = $clog2(SLOTS_PER_STATE + 1)
) (
    input  wire logic [7:0]      fields [4],
    input  wire logic [7:0]      zero_count,
    input  wire logic [SF_W-1:0] slot_fill [STATE_COUNT],
    output commit_t              result,
    output logic [IDX_W-1:0]     from_idx,
    output logic [IDX_W-1:0]     to_idx
);

    logic [7:0]      from_full;
    logic [7:0]      to_full;
    logic            bad;
    logic [SF_W-1:0] fill;

    assign from_full = fields[0] - 8'd1;
    assign to_full   = fields[2] - 8'd1;
    assign bad       = (from_full >= 8'(STATE_COUNT)) || (to_full >= 8'(STATE_COUNT));
    assign from_idx  = from_full[IDX_W-1:0];
    assign to_idx    = to_full[IDX_W-1:0];
    assign fill      = bad ? '0 : slot_fill[from_idx];

    always_comb
    begin
        result.from_state   = from_full[3:0];
        result.to_state     = to_full[3:0];
        result.read_symbol  = sym_of(fields[1]);
        result.write_symbol = sym_of(fields[3]);
        result.direction    = dir_of(zero_count);
        result.slot         = 3'd0;
        if (bad)
        begin
            result.kind = KIND_BAD_STATE;
        end
        else if (fill >= SF_W'(SLOTS_PER_STATE))
        begin
            result.kind = KIND_SLOTS_FULL;
        end
        else
        begin
            result.kind = KIND_TRANS;
            result.slot = 3'(fill);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/unary_tm_description_parser_core.sv -----
// Top level of the unary machine-description parser: input stage, parse state, result register.
//
//   channel  | dir | payload                                          | handshake
//   ---------+-----+--------------------------------------------------+----------
//   chars    | in  | ch, end_of_text                                  | valid/ready
//   results  | out | kind, transition, tape write and summary fields  | valid/ready
//
// One item per cycle sustained while results are taken; an accepted item waits in the input
// register, then reaches the result register. The parse state updates as an item leaves the
// input register, so the only loop is one register deep. Reset (rst_n low, asynchronous)
// returns the parser to expecting the leading character with empty slots. A stalled result
// register holds the input stage; the input register still takes one item while a result waits.
`default_nettype none

module unary_tm_description_parser_core import utmdp_pkg::*; #(
    parameter int STATE_COUNT     = STATE_COUNT_DEF,
    parameter int SLOTS_PER_STATE = SLOTS_PER_STATE_DEF,
    parameter int TAPE_CELLS      = TAPE_CELLS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    utmdp_in_if.sink     chars,
    utmdp_out_if.source  results
);

    localparam int IDX_W = $clog2(STATE_COUNT);
    localparam int SF_W  = $clog2(SLOTS_PER_STATE + 1);
    localparam int UC_W  = $clog2(STATE_COUNT + 1);
    localparam int TP_W  = $clog2(TAPE_CELLS + 1);

    // input stage
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       eot_reg;

    // parse state
    phase_t            phase_reg,      phase_next;
    logic [2:0]        field_idx_reg,  field_idx_next;
    logic [7:0]        zero_cnt_reg,   zero_cnt_next;
    logic [7:0]        fields_reg [4];
    logic [7:0]        fields_next [4];
    logic [1:0]        ones_reg,       ones_next;
    logic [STATE_COUNT-1:0] used_reg,  used_next;
    logic [UC_W-1:0]   used_cnt_reg,   used_cnt_next;
    logic [SF_W-1:0]   slot_fill_reg [STATE_COUNT];
    logic [SF_W-1:0]   slot_fill_next [STATE_COUNT];
    logic [7:0]        total_reg,      total_next;
    logic [TP_W-1:0]   tape_ptr_reg,   tape_ptr_next;

    // result register
    logic       out_valid_reg;
    logic [2:0] kind_reg,         kind_next;
    logic [3:0] from_state_reg,   from_state_next;
    logic [2:0] slot_reg,         slot_next;
    logic [3:0] to_state_reg,     to_state_next;
    logic [7:0] read_sym_reg,     read_sym_next;
    logic [7:0] write_sym_reg,    write_sym_next;
    logic [1:0] direction_reg,    direction_next;
    logic [7:0] tape_index_reg,   tape_index_next;
    logic [7:0] tape_char_reg,    tape_char_next;
    logic [4:0] state_count_reg,  state_count_next;
    logic [7:0] trans_count_reg,  trans_count_next;
    logic       has_result;

    logic            out_free;
    logic            advance;
    logic            go_on;
    logic            new_from;
    logic            new_to;
    commit_t         cres;
    logic [IDX_W-1:0] from_idx;
    logic [IDX_W-1:0] to_idx;

    assign out_free    = !out_valid_reg || results.ready;
    assign advance     = in_valid_reg && out_free;
    assign chars.ready = !in_valid_reg || advance;

    utmdp_commit #(
        .STATE_COUNT     (STATE_COUNT),
        .SLOTS_PER_STATE (SLOTS_PER_STATE)
    ) u_commit (
        .fields     (fields_reg),
        .zero_count (zero_cnt_reg),
        .slot_fill  (slot_fill_reg),
        .result     (cres),
        .from_idx   (from_idx),
        .to_idx     (to_idx)
    );

    assign new_from = !used_reg[from_idx];
    assign new_to   = !used_reg[to_idx] && (to_idx != from_idx);

    always_comb
    begin
        phase_next     = phase_reg;
        field_idx_next = field_idx_reg;
        zero_cnt_next  = zero_cnt_reg;
        fields_next    = fields_reg;
        ones_next      = ones_reg;
        used_next      = used_reg;
        used_cnt_next  = used_cnt_reg;
        slot_fill_next = slot_fill_reg;
        total_next     = total_reg;
        tape_ptr_next  = tape_ptr_reg;

        has_result       = 1'b0;
        kind_next        = KIND_TRANS;
        from_state_next  = 4'd0;
        slot_next        = 3'd0;
        to_state_next    = 4'd0;
        read_sym_next    = 8'd0;
        write_sym_next   = 8'd0;
        direction_next   = 2'd0;
        tape_index_next  = 8'd0;
        tape_char_next   = 8'd0;
        state_count_next = 5'd0;
        trans_count_next = 8'd0;
        go_on            = 1'b1;

        if (advance)
        begin
            if (eot_reg)
            begin
                has_result       = 1'b1;
                kind_next        = KIND_SUMMARY;
                state_count_next = 5'(used_cnt_reg);
                trans_count_next = total_reg;
                // clear everything for the next description
                phase_next     = PH_LEAD;
                field_idx_next = 3'd0;
                zero_cnt_next  = 8'd0;
                for (int i = 0; i < 4; i++)
                    fields_next[i] = 8'd0;
                ones_next      = 2'd0;
                used_next      = '0;
                used_cnt_next  = '0;
                for (int i = 0; i < STATE_COUNT; i++)
                    slot_fill_next[i] = '0;
                total_next     = 8'd0;
                tape_ptr_next  = '0;
            end
            else if (phase_reg == PH_TAPE)
            begin
                has_result      = 1'b1;
                tape_index_next = 8'(tape_ptr_reg);
                tape_char_next  = ch_reg;
                if (tape_ptr_reg == TP_W'(TAPE_CELLS))
                begin
                    kind_next = KIND_TAPE_FULL;
                end
                else
                begin
                    kind_next     = KIND_TAPE;
                    tape_ptr_next = tape_ptr_reg + 1'b1;
                end
            end
            else
            begin
                if (phase_reg == PH_LEAD)
                begin
                    phase_next = PH_TRANS;
                    // skip an optional leading one
                    if (ch_reg == CHAR_ONE)
                        go_on = 1'b0;
                end

                if (go_on && ones_reg != 2'd0)
                begin
                    if (ch_reg == CHAR_ONE)
                    begin
                        go_on = 1'b0;
                        if (ones_reg >= 2'd2)
                        begin
                            phase_next = PH_TAPE;
                            ones_next  = 2'd0;
                        end
                        else
                        begin
                            ones_next = ones_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ones_next = 2'd0;
                    end
                end

                if (go_on)
                begin
                    if (ch_reg == CHAR_ONE)
                    begin
                        if (field_idx_reg < 3'd4)
                        begin
                            fields_next[field_idx_reg[1:0]] = zero_cnt_reg;
                            field_idx_next = field_idx_reg + 3'd1;
                            zero_cnt_next  = 8'd0;
                        end
                        else
                        begin
                            has_result      = 1'b1;
                            kind_next       = cres.kind;
                            from_state_next = cres.from_state;
                            slot_next       = cres.slot;
                            to_state_next   = cres.to_state;
                            read_sym_next   = cres.read_symbol;
                            write_sym_next  = cres.write_symbol;
                            direction_next  = cres.direction;
                            field_idx_next  = 3'd0;
                            zero_cnt_next   = 8'd0;
                            ones_next       = 2'd1;
                            if (cres.kind == KIND_TRANS)
                            begin
                                slot_fill_next[from_idx] = slot_fill_reg[from_idx] + 1'b1;
                                used_next[from_idx] = 1'b1;
                                used_next[to_idx]   = 1'b1;
                                used_cnt_next = used_cnt_reg + UC_W'(new_from) + UC_W'(new_to);
                                if (total_reg != 8'hFF)
                                    total_next = total_reg + 8'd1;
                            end
                        end
                    end
                    else if (ch_reg == CHAR_ZERO && zero_cnt_reg != 8'hFF)
                    begin
                        zero_cnt_next = zero_cnt_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LEAD;
            field_idx_reg <= 3'd0;
            zero_cnt_reg  <= 8'd0;
            for (int i = 0; i < 4; i++)
                fields_reg[i] <= 8'd0;
            ones_reg      <= 2'd0;
            used_reg      <= '0;
            used_cnt_reg  <= '0;
            for (int i = 0; i < STATE_COUNT; i++)
                slot_fill_reg[i] <= '0;
            total_reg     <= 8'd0;
            tape_ptr_reg  <= '0;
        end
        else
        begin
            if (chars.valid && chars.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= has_result;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            phase_reg     <= phase_next;
            field_idx_reg <= field_idx_next;
            zero_cnt_reg  <= zero_cnt_next;
            fields_reg    <= fields_next;
            ones_reg      <= ones_next;
            used_reg      <= used_next;
            used_cnt_reg  <= used_cnt_next;
            slot_fill_reg <= slot_fill_next;
            total_reg     <= total_next;
            tape_ptr_reg  <= tape_ptr_next;
        end
    end

    // payload registers: load input on accept, result on advance
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg  <= chars.ch;
            eot_reg <= chars.end_of_text;
        end
        if (advance)
        begin
            kind_reg        <= kind_next;
            from_state_reg  <= from_state_next;
            slot_reg        <= slot_next;
            to_state_reg    <= to_state_next;
            read_sym_reg    <= read_sym_next;
            write_sym_reg   <= write_sym_next;
            direction_reg   <= direction_next;
            tape_index_reg  <= tape_index_next;
            tape_char_reg   <= tape_char_next;
            state_count_reg <= state_count_next;
            trans_count_reg <= trans_count_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.kind             = kind_reg;
    assign results.from_state       = from_state_reg;
    assign results.slot             = slot_reg;
    assign results.to_state         = to_state_reg;
    assign results.read_symbol      = read_sym_reg;
    assign results.write_symbol     = write_sym_reg;
    assign results.direction        = direction_reg;
    assign results.tape_index       = tape_index_reg;
    assign results.tape_char        = tape_char_reg;
    assign results.state_count      = state_count_reg;
    assign results.transition_count = trans_count_reg;
    assign results.last             = 1'b1;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the unary machine-description parser core.
module tb_top;
    import utmdp_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 300;

    localparam logic [7:0] CHAR_A         = 8'h61;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] FIRST_LETTER   = 8'd3;
    localparam logic [7:0] PAST_LETTERS   = 8'd29;
    localparam logic [7:0] RUN_SATURATION = 8'hFF;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] from_state;
        logic [2:0] slot;
        logic [3:0] to_state;
        logic [7:0] read_symbol;
        logic [7:0] write_symbol;
        logic [1:0] direction;
        logic [7:0] tape_index;
        logic [7:0] tape_char;
        logic [4:0] state_count;
        logic [7:0] transition_count;
        logic       last;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    utmdp_in_if  chars_if ();
    utmdp_out_if results_if ();

    unary_tm_description_parser_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    // Parser mirror
    phase_t      ph;
    logic [2:0]  field_idx;
    logic [7:0]  zero_run;
    logic [7:0]  fields [4];
    logic [1:0]  ones_run;
    logic [15:0] used_states;
    logic [3:0]  slot_fill [STATE_COUNT_DEF];
    logic [7:0]  committed;
    logic [8:0]  tape_ptr;

    parse_result_t pending_results [$];

    int mismatches = 0;
    int items_sent = 0;
    int src_idle   = 0;
    int snk_idle   = 0;
    int noise_pct  = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    function automatic void clear_parser();
        ph          = PH_LEAD;
        field_idx   = '0;
        zero_run    = '0;
        ones_run    = '0;
        used_states = '0;
        committed   = '0;
        tape_ptr    = '0;
        for (int i = 0; i < 4; i++)
            fields[i] = '0;
        for (int i = 0; i < STATE_COUNT_DEF; i++)
            slot_fill[i] = '0;
    endfunction

    function automatic logic [7:0] symbol_for(input logic [7:0] zeros);
        logic [7:0] idx;
        idx = zeros - 8'd1;
        case (idx)
            8'd0:    return CHAR_ZERO;
            8'd1:    return CHAR_ONE;
            8'd2:    return CHAR_BLANK;
            default: return (idx < PAST_LETTERS) ? CHAR_A + (idx - FIRST_LETTER) : CHAR_BLANK;
        endcase
    endfunction

    function automatic logic [1:0] heading_for(input logic [7:0] zeros);
        case (zeros)
            8'd1:    return DIR_LEFT;
            8'd2:    return DIR_RIGHT;
            default: return DIR_NONE;
        endcase
    endfunction

    // Close the direction field: fill in the transition and place it in a slot
    function automatic void close_transition(inout parse_result_t r);
        logic [7:0] src;
        logic [7:0] dst;
        src = fields[0] - 8'd1;
        dst = fields[2] - 8'd1;
        r.from_state   = src[3:0];
        r.to_state     = dst[3:0];
        r.read_symbol  = symbol_for(fields[1]);
        r.write_symbol = symbol_for(fields[3]);
        r.direction    = heading_for(zero_run);
        if (src >= STATE_COUNT_DEF || dst >= STATE_COUNT_DEF)
            r.kind = KIND_BAD_STATE;
        else if (slot_fill[src[3:0]] >= SLOTS_PER_STATE_DEF)
            r.kind = KIND_SLOTS_FULL;
        else
        begin
            r.kind = KIND_TRANS;
            r.slot = slot_fill[src[3:0]][2:0];
            slot_fill[src[3:0]]++;
            used_states[src[3:0]] = 1'b1;
            used_states[dst[3:0]] = 1'b1;
            if (committed != 8'hFF)
                committed++;
        end
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic eot);
        parse_result_t r;
        r      = '0;
        r.last = 1'b1;
        if (eot)
        begin
            r.kind             = KIND_SUMMARY;
            r.state_count      = 5'($countones(used_states));
            r.transition_count = committed;
            clear_parser();
            pending_results.push_back(r);
            return;
        end
        if (ph == PH_TAPE)
        begin
            r.tape_index = tape_ptr[7:0];
            r.tape_char  = c;
            if (tape_ptr >= TAPE_CELLS_DEF)
                r.kind = KIND_TAPE_FULL;
            else
            begin
                r.kind = KIND_TAPE;
                tape_ptr++;
            end
            pending_results.push_back(r);
            return;
        end
        if (ph == PH_LEAD)
        begin
            ph = PH_TRANS;
            if (c == CHAR_ONE)
                return;
        end
        if (ones_run != 0)
        begin
            if (c == CHAR_ONE)
            begin
                if (ones_run >= 2)
                begin
                    ph       = PH_TAPE;
                    ones_run = '0;
                end
                else
                    ones_run++;
                return;
            end
            ones_run = '0;
        end
        if (c == CHAR_ONE)
        begin
            if (field_idx < 4)
            begin
                fields[field_idx[1:0]] = zero_run;
                field_idx++;
                zero_run = '0;
                return;
            end
            close_transition(r);
            field_idx = '0;
            zero_run  = '0;
            ones_run  = 2'd1;
            pending_results.push_back(r);
            return;
        end
        if (c == CHAR_ZERO && zero_run != RUN_SATURATION)
            zero_run++;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare results, predict on accepted items, watch for a hang
    always @(posedge clk)
    begin : monitor
        parse_result_t seen;
        parse_result_t want;
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
            begin
                seen.kind             = kind_t'(results_if.kind);
                seen.from_state       = results_if.from_state;
                seen.slot             = results_if.slot;
                seen.to_state         = results_if.to_state;
                seen.read_symbol      = results_if.read_symbol;
                seen.write_symbol     = results_if.write_symbol;
                seen.direction        = results_if.direction;
                seen.tape_index       = results_if.tape_index;
                seen.tape_char        = results_if.tape_char;
                seen.state_count      = results_if.state_count;
                seen.transition_count = results_if.transition_count;
                seen.last             = results_if.last;
                if (pending_results.size() == 0)
                begin
                    $error("result with kind %0d arrived with nothing expected", seen.kind);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, seen.kind);
                    check_field("from_state", want.from_state, seen.from_state);
                    check_field("slot", want.slot, seen.slot);
                    check_field("to_state", want.to_state, seen.to_state);
                    check_field("read_symbol", want.read_symbol, seen.read_symbol);
                    check_field("write_symbol", want.write_symbol, seen.write_symbol);
                    check_field("direction", want.direction, seen.direction);
                    check_field("tape_index", want.tape_index, seen.tape_index);
                    check_field("tape_char", want.tape_char, seen.tape_char);
                    check_field("state_count", want.state_count, seen.state_count);
                    check_field("transition_count", want.transition_count,
                                seen.transition_count);
                    check_field("last", want.last, seen.last);
                end
            end
            if (chars_if.valid && chars_if.ready)
                parse_char(chars_if.ch, chars_if.end_of_text);
            if ((results_if.valid && results_if.ready) || (chars_if.valid && chars_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    initial
    begin
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                results_if.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else
                results_if.ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eot = 1'b0);
        while ($urandom_range(0, 99) < src_idle)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid       <= 1'b1;
        chars_if.ch          <= c;
        chars_if.end_of_text <= eot;
        do
            @(posedge clk);
        while (!chars_if.ready);
        items_sent++;
    endtask

    task automatic send_end();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_ZERO || c == CHAR_ONE)
            c = CHAR_SPACE;
        return c;
    endfunction

    task automatic send_field(input int unsigned zeros);
        for (int i = 0; i < zeros; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_char(filler_char());
            send_char(CHAR_ZERO);
        end
        send_char(CHAR_ONE);
    endtask

    task automatic send_transition(input int unsigned st, input int unsigned rd,
                                   input int unsigned nx, input int unsigned wr,
                                   input int unsigned mv, input int nfields = 5);
        int unsigned f [5];
        f = '{st, rd, nx, wr, mv};
        for (int k = 0; k < nfields; k++)
            send_field(f[k]);
    endtask

    // Lower valid and hold until every expected result has come back
    task automatic wait_results_drained();
        chars_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_transition_fields();
        send_end();
        send_char(CHAR_ONE);
        send_transition(1, 1, 2, 2, 1);
        send_char(CHAR_ONE);
        send_transition(2, 3, 1, 4, 2);
        send_char(CHAR_ONE);
        send_transition(16, 29, 16, 30, 3);
        send_char(CHAR_ONE);
        send_transition(3, 0, 4, 31, 0);
        // third one after a transition enters tape mode, fourth is a tape write
        send_char(CHAR_ONE);
        send_char(CHAR_ONE);
        send_char(CHAR_ONE);
        send_end();
        wait_results_drained();
    endtask

    task automatic test_bad_state();
        send_end();
        send_char(CHAR_ONE);
        send_transition(0, 1, 1, 1, 1);
        send_char(CHAR_ONE);
        send_transition(17, 1, 1, 1, 1);
        send_char(CHAR_ONE);
        send_transition(1, 1, 0, 1, 1);
        send_char(CHAR_ONE);
        send_transition(1, 1, 17, 1, 2);
        send_end();
        wait_results_drained();
    endtask

    // saturated state and read-symbol runs differ visibly from wrapped ones
    task automatic test_long_field();
        send_end();
        send_char(CHAR_ONE);
        send_transition(256, 260, 1, 1, 1);
        send_end();
        wait_results_drained();
    endtask

    task automatic test_slots_full();
        send_end();
        send_char(CHAR_ONE);
        repeat (SLOTS_PER_STATE_DEF + 1)
        begin
            send_transition(4, 1, 4, 2, 2);
            send_char(CHAR_ONE);
        end
        send_end();
        wait_results_drained();
    endtask

    task automatic test_all_states();
        send_end();
        send_char(CHAR_ONE);
        for (int i = 0; i < STATE_COUNT_DEF / 2; i++)
        begin
            send_transition(i + 1, 2, STATE_COUNT_DEF - i, 3, 1);
            send_char(CHAR_ONE);
        end
        send_end();
        wait_results_drained();
    endtask

    task automatic test_tape_overflow();
        send_end();
        send_char(CHAR_ONE);
        send_transition(1, 1, 1, 1, 1);
        send_char(CHAR_ONE);
        send_char(CHAR_ONE);
        for (int i = 0; i < TAPE_CELLS_DEF + 2; i++)
        begin
            if (i == 0)
                send_char(8'h00);
            else if (i == 1)
                send_char(8'hFF);
            else if (i == 2)
                send_char(CHAR_ONE);
            else
                send_char(8'($urandom_range(0, 255)));
        end
        send_end();
        send_end();
        wait_results_drained();
    endtask

    task automatic test_unfinished();
        send_end();
        // a lead other than one is parsed as an ordinary character
        send_char(CHAR_ZERO);
        send_char(8'h00);
        send_char(CHAR_ONE);
        send_field(2);
        send_char(8'h00);
        send_end();
        send_char(CHAR_ONE);
        send_transition(5, 6, 7, 8, 2);
        send_end();
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        send_end();
        send_char(CHAR_ONE);
        send_transition(2, 2, 2, 2, 2);
        send_char(CHAR_ONE);
        send_char(CHAR_ONE);
        hold_left <= HOLD_CYCLES;
        repeat (40)
            send_char(8'($urandom_range(0, 255)));
        send_end();
        wait_results_drained();
    endtask

    function automatic int unsigned pick_state(input bit narrow);
        int unsigned r;
        if (narrow)
            return $urandom_range(1, 2);
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(STATE_COUNT_DEF + 1, STATE_COUNT_DEF + 4);
        return $urandom_range(1, STATE_COUNT_DEF);
    endfunction

    task automatic send_random_description();
        int unsigned pick;
        int unsigned n_trans;
        int          cut;
        bit          narrow;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // noise, occasionally with a stray terminator
            repeat ($urandom_range(1, 8))
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            return;
        end
        noise_pct = ($urandom_range(0, 3) == 0) ? 10 : 0;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            send_char(CHAR_ONE);
        else if (pick < 8)
            send_char(filler_char());
        narrow  = ($urandom_range(0, 4) == 0);
        n_trans = narrow ? $urandom_range(6, 12) : $urandom_range(1, 6);
        cut     = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : 5;
        for (int i = 0; i < n_trans; i++)
        begin
            if (i == n_trans - 1 && cut < 5)
            begin
                // drop an unfinished transition at the terminator
                send_transition(pick_state(narrow), $urandom_range(0, 31),
                                pick_state(narrow), $urandom_range(0, 31),
                                $urandom_range(0, 3), cut);
                send_end();
                return;
            end
            send_transition(pick_state(narrow), $urandom_range(0, 31),
                            pick_state(narrow), $urandom_range(0, 31),
                            $urandom_range(0, 3));
            if (i != n_trans - 1 && $urandom_range(0, 99) < 85)
                send_char(CHAR_ONE);
        end
        if ($urandom_range(0, 9) < 4)
        begin
            send_char(CHAR_ONE);
            send_char(CHAR_ONE);
            repeat ($urandom_range(0, 24))
                send_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) != 0)
            send_end();
    endtask

    task automatic test_random(input int src, input int snk, input int n);
        int target;
        src_idle = src;
        snk_idle = snk;
        target   = items_sent + n;
        while (items_sent < target)
            send_random_description();
        noise_pct = 0;
        wait_results_drained();
    endtask

    initial
    begin
        clear_parser();
        rst_n                <= 1'b0;
        chars_if.valid       <= 1'b0;
        chars_if.ch          <= '0;
        chars_if.end_of_text <= 1'b0;
        src_idle = 22;
        snk_idle = 54;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_transition_fields();
        test_bad_state();
        test_long_field();
        test_slots_full();
        test_all_states();
        test_tape_overflow();
        test_unfinished();
        test_backpressure();

        test_random(22, 54, RANDOM_ITEMS / 3);
        test_random(54, 22, RANDOM_ITEMS / 3);
        test_random(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/utmdp_pkg.sv
hdl/utmdp_if.sv
hdl/utmdp_commit.sv
hdl/unary_tm_description_parser_core.sv
dv/tb_top.sv
